### src/simple_glyph_outline_check_macros.svh
// assertion helpers, compiled away for synthesis
`ifndef SIMPLE_GLYPH_OUTLINE_CHECK_MACROS_SVH
`define SIMPLE_GLYPH_OUTLINE_CHECK_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge out of reset
`define SGOC_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("sgoc assertion failed");

// condition must never be seen at a clock edge out of reset
`define SGOC_ASSERT_NEVER(name, clk, rst_n, cond) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("sgoc forbidden condition seen");

`else

`define SGOC_ASSERT(name, clk, rst_n, prop)
`define SGOC_ASSERT_NEVER(name, clk, rst_n, cond)

`endif

`endif

### src/sgoc_pkg.sv
`default_nettype none

package sgoc_pkg;

  // header is contour count (2 bytes) plus bounding box (8 bytes)
  localparam int unsigned HeaderBytes = 10;
  localparam int unsigned PosBits     = 4;
  localparam logic [PosBits-1:0] PosLast = PosBits'(HeaderBytes - 1);

  // flag bits
  localparam logic [7:0] FLAG_X_SHORT = 8'h02;
  localparam logic [7:0] FLAG_Y_SHORT = 8'h04;
  localparam logic [7:0] FLAG_REPEAT  = 8'h08;
  localparam logic [7:0] FLAG_X_SAME  = 8'h10;
  localparam logic [7:0] FLAG_Y_SAME  = 8'h20;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_TRUNC      = 3'd1,
    ST_ORDER      = 3'd2,
    ST_REPEAT     = 3'd3,
    ST_NOT_SIMPLE = 3'd4
  } status_e;

  typedef enum logic [7:0] {
    PH_HEADER    = 8'b0000_0001,
    PH_ENDPOINTS = 8'b0000_0010,
    PH_ILEN      = 8'b0000_0100,
    PH_INSTR     = 8'b0000_1000,
    PH_FLAGS     = 8'b0001_0000,
    PH_REPEAT    = 8'b0010_0000,
    PH_COORDS    = 8'b0100_0000,
    PH_DONE      = 8'b1000_0000
  } phase_e;

  // one byte handed from the input register to the checker
  typedef struct packed {
    logic       take;
    logic [7:0] data;
    logic       last;
  } sgoc_item_t;

  // verdict for the record that ends with the current byte
  typedef struct packed {
    status_e     status;
    logic [16:0] count;
  } sgoc_res_t;

  // coordinate bytes needed by one point with this flag
  function automatic logic [2:0] flag_cost(input logic [7:0] f);
    logic [1:0] cx;
    logic [1:0] cy;
    cx = ((f & FLAG_X_SHORT) != 8'h00) ? 2'd1 :
         (((f & FLAG_X_SAME) != 8'h00) ? 2'd0 : 2'd2);
    cy = ((f & FLAG_Y_SHORT) != 8'h00) ? 2'd1 :
         (((f & FLAG_Y_SAME) != 8'h00) ? 2'd0 : 2'd2);
    return {1'b0, cx} + {1'b0, cy};
  endfunction

endpackage

`default_nettype wire

### src/simple_glyph_outline_check.sv
// simple glyph outline check: one glyph byte per transfer, last byte marked
// throughput: one byte per cycle, sustained, as long as results are taken
// verdict path: the last byte waits in the input register until the result
//   register is free, then its verdict is registered in the result register
// reset: asynchronous, active low; clears the check state and the valid bit
//   of both registers; the check state also restarts after every last byte
`default_nettype none

`include "simple_glyph_outline_check_macros.svh"

module simple_glyph_outline_check (
  input  wire         clk_i,
  input  wire         rst_ni,
  // byte stream
  input  wire         in_valid_i,
  output logic        in_stall_o,
  input  wire  [7:0]  glyph_byte_i,
  input  wire         last_byte_i,
  // verdicts
  output logic        out_valid_o,
  input  wire         out_stall_i,
  output logic [2:0]  status_o,
  output logic [16:0] point_count_o
);
  import sgoc_pkg::*;

  // input register
  logic       s1_valid_q;
  logic [7:0] s1_byte_q;
  logic       s1_last_q;

  // result register
  logic        out_valid_q;
  status_e     out_status_q;
  logic [16:0] out_count_q;

  logic       out_free;
  logic       s1_fire;
  sgoc_item_t item;
  sgoc_res_t  res;

  // result register can take a verdict this cycle
  assign out_free = !out_valid_q || !out_stall_i;

  // bytes that end no record never wait on the output side
  assign s1_fire    = s1_valid_q && (!s1_last_q || out_free);
  assign in_stall_o = s1_valid_q && !s1_fire;

  assign item.take = s1_fire;
  assign item.data = s1_byte_q;
  assign item.last = s1_last_q;

  sgoc_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .item_i (item),
    .res_o  (res)
  );

  // input register: refills whenever its byte moves on or it is empty
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o) begin
      s1_byte_q <= glyph_byte_i;
      s1_last_q <= last_byte_i;
    end
  end

  // result register: loaded by the last byte of a record
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_fire && s1_last_q) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire && s1_last_q) begin
      out_status_q <= res.status;
      out_count_q  <= res.count;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign point_count_o = out_count_q;

  `SGOC_ASSERT(a_verdict_loaded, clk_i, rst_ni, (s1_fire && s1_last_q) |=> out_valid_q)
  `SGOC_ASSERT_NEVER(a_stall_without_byte, clk_i, rst_ni, in_stall_o && !s1_valid_q)

endmodule

`default_nettype wire

### src/sgoc_core.sv
`default_nettype none

`include "simple_glyph_outline_check_macros.svh"

module sgoc_core (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire sgoc_pkg::sgoc_item_t item_i,
  output sgoc_pkg::sgoc_res_t  res_o
);
  import sgoc_pkg::*;

  phase_e             phase_q, phase_d;
  logic [PosBits-1:0] pos_q, pos_d;
  logic [15:0]        total_q, total_d;
  logic [15:0]        seen_q, seen_d;
  logic [15:0]        prev_q, prev_d;
  logic [7:0]         hold_q, hold_d;
  logic               half_q, half_d;
  logic [15:0]        instr_q, instr_d;
  logic [16:0]        points_q, points_d;
  logic [7:0]         flag_q, flag_d;
  logic [18:0]        coord_q, coord_d;
  status_e            err_q, err_d;

  logic [15:0] word;
  logic [15:0] seen_inc;
  logic [8:0]  run_len;
  logic [10:0] run_cost;
  logic [18:0] coord_flag;
  logic [18:0] coord_run;
  logic [16:0] points_run;
  logic        in_flag_phase;
  logic        err_held;

  assign word       = {hold_q, item_i.data};
  assign seen_inc   = seen_q + 16'd1;
  assign run_len    = {1'b0, item_i.data} + 9'd1;
  assign run_cost   = 11'(run_len) * 11'(flag_cost(flag_q));
  assign coord_flag = coord_q + 19'(flag_cost(item_i.data));
  assign coord_run  = coord_q + 19'(run_cost);
  assign points_run = points_q - 17'(run_len);

  always_comb begin
    phase_d  = phase_q;
    pos_d    = pos_q;
    total_d  = total_q;
    seen_d   = seen_q;
    prev_d   = prev_q;
    hold_d   = hold_q;
    half_d   = half_q;
    instr_d  = instr_q;
    points_d = points_q;
    flag_d   = flag_q;
    coord_d  = coord_q;
    err_d    = err_q;

    if (item_i.take && err_q == ST_OK) begin
      case (phase_q)
        PH_HEADER: begin
          if (pos_q == '0) begin
            hold_d = item_i.data;
          end else if (pos_q == PosBits'(1)) begin
            total_d = word;
          end
          if (pos_q == PosLast) begin
            // signed count must be positive
            if (total_q == '0 || total_q[15]) begin
              err_d = ST_NOT_SIMPLE;
            end else begin
              phase_d = PH_ENDPOINTS;
              half_d  = 1'b0;
            end
          end
        end
        PH_ENDPOINTS: begin
          if (!half_q) begin
            hold_d = item_i.data;
            half_d = 1'b1;
          end else begin
            half_d = 1'b0;
            if (seen_q != '0 && word <= prev_q) begin
              err_d = ST_ORDER;
            end else begin
              prev_d = word;
              seen_d = seen_inc;
              if (seen_inc >= total_q) begin
                phase_d = PH_ILEN;
              end
            end
          end
        end
        PH_ILEN: begin
          if (!half_q) begin
            hold_d = item_i.data;
            half_d = 1'b1;
          end else begin
            half_d   = 1'b0;
            instr_d  = word;
            points_d = {1'b0, prev_q} + 17'd1;
            coord_d  = '0;
            phase_d  = (word == '0) ? PH_FLAGS : PH_INSTR;
          end
        end
        PH_INSTR: begin
          instr_d = instr_q - 16'd1;
          if (instr_q == 16'd1) begin
            phase_d = PH_FLAGS;
          end
        end
        PH_FLAGS: begin
          flag_d = item_i.data;
          if ((item_i.data & FLAG_REPEAT) != 8'h00) begin
            phase_d = PH_REPEAT;
          end else begin
            coord_d  = coord_flag;
            points_d = points_q - 17'd1;
            if (points_q == 17'd1) begin
              phase_d = (coord_flag == '0) ? PH_DONE : PH_COORDS;
            end
          end
        end
        PH_REPEAT: begin
          if ({9'd0, item_i.data} >= points_q) begin
            err_d = ST_REPEAT;
          end else begin
            coord_d  = coord_run;
            points_d = points_run;
            phase_d  = PH_FLAGS;
            if (points_run == '0) begin
              phase_d = (coord_run == '0) ? PH_DONE : PH_COORDS;
            end
          end
        end
        PH_COORDS: begin
          // counts the coordinate bytes down to zero
          coord_d = coord_q - 19'd1;
          if (coord_q == 19'd1) begin
            phase_d = PH_DONE;
          end
        end
        PH_DONE: begin
          // trailing bytes ignored
        end
        default: begin
          phase_d = phase_q;
        end
      endcase
    end

    if (item_i.take && pos_q != PosLast) begin
      pos_d = pos_q + PosBits'(1);
    end
  end

  always_comb begin
    res_o.status = err_d;
    if (err_d == ST_OK && phase_d != PH_DONE) begin
      res_o.status = ST_TRUNC;
    end
    if (phase_d inside {PH_HEADER, PH_ENDPOINTS}) begin
      res_o.count = '0;
    end else begin
      res_o.count = {1'b0, prev_d} + 17'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HEADER;
      pos_q    <= '0;
      total_q  <= '0;
      seen_q   <= '0;
      prev_q   <= '0;
      hold_q   <= '0;
      half_q   <= 1'b0;
      instr_q  <= '0;
      points_q <= '0;
      flag_q   <= '0;
      coord_q  <= '0;
      err_q    <= ST_OK;
    end else if (item_i.take && item_i.last) begin
      // record done, back to the start state
      phase_q  <= PH_HEADER;
      pos_q    <= '0;
      total_q  <= '0;
      seen_q   <= '0;
      prev_q   <= '0;
      hold_q   <= '0;
      half_q   <= 1'b0;
      instr_q  <= '0;
      points_q <= '0;
      flag_q   <= '0;
      coord_q  <= '0;
      err_q    <= ST_OK;
    end else begin
      phase_q  <= phase_d;
      pos_q    <= pos_d;
      total_q  <= total_d;
      seen_q   <= seen_d;
      prev_q   <= prev_d;
      hold_q   <= hold_d;
      half_q   <= half_d;
      instr_q  <= instr_d;
      points_q <= points_d;
      flag_q   <= flag_d;
      coord_q  <= coord_d;
      err_q    <= err_d;
    end
  end

  // flag phases always have points left to fill
  assign in_flag_phase = (phase_q == PH_FLAGS) || (phase_q == PH_REPEAT);
  // a mid-record byte arriving after an error
  assign err_held      = item_i.take && !item_i.last && (err_q != ST_OK);

  `SGOC_ASSERT(a_coords_pending, clk_i, rst_ni, (phase_q == PH_COORDS) |-> (coord_q != '0))
  `SGOC_ASSERT(a_points_pending, clk_i, rst_ni, in_flag_phase |-> (points_q != '0))
  `SGOC_ASSERT(a_error_sticky, clk_i, rst_ni, err_held |=> (err_q == $past(err_q)))

endmodule

`default_nettype wire

### verif/simple_glyph_outline_check_tb.sv
`timescale 1ns / 1ps

module simple_glyph_outline_check_tb;
  import sgoc_pkg::*;

  // random part size and the quiet tail at the end of the run
  localparam int RandomBytes      = 220;
  localparam int MinRandomRecords = 8;
  localparam int TailBytes        = 150;
  // cycles without any transfer before the run is declared hung
  localparam int WatchdogCycles   = 2000;
  // verdict is registered behind the last byte, so a short drain is plenty
  localparam int DrainCycles      = 10;

  // one byte transfer on the input channel
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } glyph_xfer_t;

  // ways a generated glyph can be broken on purpose
  typedef enum int {
    FAULT_NONE,
    FAULT_ORDER,
    FAULT_REPEAT
  } glyph_fault_e;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        drv_valid = 1'b0;
  logic [7:0]  drv_byte = 8'h00;
  logic        drv_last = 1'b0;
  logic        drv_stall = 1'b0;
  logic        in_stall;
  logic        out_valid;
  logic [2:0]  status;
  logic [16:0] point_count;

  // stimulus and expectations
  glyph_xfer_t bytes_pending [$];
  logic [7:0]  rec_buf [$];
  sgoc_res_t   verdicts_due [$];

  // handshake bookkeeping between the sampling and driving edges
  logic        byte_taken = 1'b0;
  int          in_gap = 0;
  int          stall_gap = 0;
  int          idle_cycles = 0;
  int          fail_count = 0;

  // no bits, each bit alone, both short, both same, short with same per axis
  logic [7:0]  flag_mix [0:8] = '{8'h00, 8'h02, 8'h04, 8'h06, 8'h10,
                                  8'h20, 8'h30, 8'h12, 8'h24};

  // predictor state for the record in flight
  phase_e      chk_phase;
  status_e     chk_error;
  logic [19:0] chk_pos;
  logic [15:0] chk_contours;
  logic [15:0] chk_seen_ep;
  logic [15:0] chk_prev_ep;
  logic [7:0]  chk_hold;
  logic        chk_half;
  logic [15:0] chk_instr_left;
  logic [16:0] chk_pts_left;
  logic [7:0]  chk_flag;
  logic [18:0] chk_need;
  logic [19:0] chk_coords;

  simple_glyph_outline_check i_dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (drv_valid),
    .in_stall_o   (in_stall),
    .glyph_byte_i (drv_byte),
    .last_byte_i  (drv_last),
    .out_valid_o  (out_valid),
    .out_stall_i  (drv_stall),
    .status_o     (status),
    .point_count_o(point_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // coordinate bytes one point with this flag needs on x and y together
  function automatic int coord_bytes(input logic [7:0] f);
    int n;
    n = 0;
    if ((f & FLAG_X_SHORT) != 8'h00) n += 1;
    else if ((f & FLAG_X_SAME) == 8'h00) n += 2;
    if ((f & FLAG_Y_SHORT) != 8'h00) n += 1;
    else if ((f & FLAG_Y_SAME) == 8'h00) n += 2;
    return n;
  endfunction

  // back to the start of a record
  task automatic restart_glyph();
    chk_phase      = PH_HEADER;
    chk_error      = ST_OK;
    chk_pos        = '0;
    chk_contours   = '0;
    chk_seen_ep    = '0;
    chk_prev_ep    = '0;
    chk_hold       = '0;
    chk_half       = 1'b0;
    chk_instr_left = '0;
    chk_pts_left   = '0;
    chk_flag       = '0;
    chk_need       = '0;
    chk_coords     = '0;
  endtask

  // once every point has its flag, wait for the coordinates if any
  task automatic flags_complete();
    if (chk_pts_left == 17'd0) begin
      chk_phase = (chk_need == 19'd0) ? PH_DONE : PH_COORDS;
    end
  endtask

  // walk one accepted byte through the record and queue a verdict on the last
  task automatic judge_glyph_byte(input logic [7:0] b, input logic last);
    logic [15:0] word;
    status_e     verdict;
    sgoc_res_t   res;
    word = {chk_hold, b};
    if (chk_error == ST_OK) begin
      case (chk_phase)
        PH_HEADER: begin
          if (chk_pos == 20'd0) chk_hold = b;
          else if (chk_pos == 20'd1) chk_contours = word;
          if (chk_pos == 20'(HeaderBytes - 1)) begin
            // contour count is signed and must be above zero
            if (chk_contours == 16'd0 || chk_contours[15]) begin
              chk_error = ST_NOT_SIMPLE;
            end else begin
              chk_phase = PH_ENDPOINTS;
              chk_half  = 1'b0;
            end
          end
        end
        PH_ENDPOINTS: begin
          if (!chk_half) begin
            chk_hold = b;
            chk_half = 1'b1;
          end else begin
            chk_half = 1'b0;
            if (chk_seen_ep != 16'd0 && word <= chk_prev_ep) begin
              chk_error = ST_ORDER;
            end else begin
              chk_prev_ep = word;
              chk_seen_ep = chk_seen_ep + 16'd1;
              if (chk_seen_ep >= chk_contours) chk_phase = PH_ILEN;
            end
          end
        end
        PH_ILEN: begin
          if (!chk_half) begin
            chk_hold = b;
            chk_half = 1'b1;
          end else begin
            chk_half       = 1'b0;
            chk_instr_left = word;
            chk_pts_left   = {1'b0, chk_prev_ep} + 17'd1;
            chk_need       = '0;
            chk_coords     = '0;
            chk_phase      = (word == 16'd0) ? PH_FLAGS : PH_INSTR;
          end
        end
        PH_INSTR: begin
          chk_instr_left = chk_instr_left - 16'd1;
          if (chk_instr_left == 16'd0) chk_phase = PH_FLAGS;
        end
        PH_FLAGS: begin
          chk_flag = b;
          if ((b & FLAG_REPEAT) != 8'h00) begin
            chk_phase = PH_REPEAT;
          end else begin
            chk_need     = chk_need + 19'(coord_bytes(b));
            chk_pts_left = chk_pts_left - 17'd1;
            flags_complete();
          end
        end
        PH_REPEAT: begin
          // repeat count must leave room inside the point total
          if ({9'd0, b} >= chk_pts_left) begin
            chk_error = ST_REPEAT;
          end else begin
            chk_need     = chk_need + 19'((int'(b) + 1) * coord_bytes(chk_flag));
            chk_pts_left = chk_pts_left - 17'(b) - 17'd1;
            chk_phase    = PH_FLAGS;
            flags_complete();
          end
        end
        PH_COORDS: begin
          chk_coords = chk_coords + 20'd1;
          if (chk_coords >= 20'(chk_need)) chk_phase = PH_DONE;
        end
        default: begin
          // trailing bytes after the coordinates
        end
      endcase
    end
    if (chk_pos != '1) chk_pos = chk_pos + 20'd1;
    if (last) begin
      verdict = chk_error;
      if (verdict == ST_OK && chk_phase != PH_DONE) verdict = ST_TRUNC;
      res.status = verdict;
      // one-hot phase codes grow in walk order, so the compare holds
      res.count  = (chk_phase >= PH_ILEN) ? ({1'b0, chk_prev_ep} + 17'd1) : 17'd0;
      verdicts_due.insert(verdicts_due.size(), res);
      restart_glyph();
    end
  endtask

  // record building helpers
  task automatic put_byte(input logic [7:0] b);
    rec_buf.insert(rec_buf.size(), b);
  endtask

  task automatic put_word(input logic [15:0] w);
    put_byte(w[15:8]);
    put_byte(w[7:0]);
  endtask

  task automatic put_random(input int n);
    repeat (n) put_byte(8'($urandom));
  endtask

  task automatic put_header(input logic [15:0] contours);
    put_word(contours);
    put_random(8);
  endtask

  // move the record into the pending stream with its last byte marked
  task automatic end_record();
    glyph_xfer_t x;
    for (int i = 0; i < rec_buf.size(); i++) begin
      x.data = rec_buf[i];
      x.last = (i == rec_buf.size() - 1);
      bytes_pending.insert(bytes_pending.size(), x);
    end
    rec_buf.delete();
  endtask

  // well-formed simple glyph with random content, optionally broken
  task automatic build_glyph(input int ncont, input int span, input int ilen,
                             input glyph_fault_e fault);
    int         k;
    int         ep;
    int         prev;
    int         left;
    int         r;
    int         coords;
    int         bad_at;
    logic [7:0] f;
    put_header(16'(ncont));
    ep     = -1;
    bad_at = (ncont > 1) ? $urandom_range(1, ncont - 1) : -1;
    for (k = 0; k < ncont; k++) begin
      prev = ep;
      ep   = ep + $urandom_range(1, span);
      // equal or falling endpoint
      if (fault == FAULT_ORDER && k == bad_at) begin
        ep = prev - $urandom_range(0, (prev < 3) ? prev : 3);
      end
      put_word(16'(ep));
    end
    put_word(16'(ilen));
    put_random(ilen);
    left   = ep + 1;
    coords = 0;
    if (fault == FAULT_REPEAT && left <= 255) begin
      // repeat count that runs past the point total
      put_byte(8'($urandom) | FLAG_REPEAT);
      put_byte(8'($urandom_range(left, 255)));
      put_random($urandom_range(0, 4));
      return;
    end
    while (left > 0) begin
      f = 8'($urandom);
      if ($urandom_range(0, 9) < 3) f = f | FLAG_REPEAT;
      else f = f & ~FLAG_REPEAT;
      put_byte(f);
      r = 0;
      if ((f & FLAG_REPEAT) != 8'h00) begin
        r = $urandom_range(0, (left > 256) ? 255 : left - 1);
        put_byte(8'(r));
      end
      left   -= r + 1;
      coords += (r + 1) * coord_bytes(f);
    end
    put_random(coords);
  endtask

  // driver: new byte or gap after each transfer, payload held while stalled
  always @(negedge clk) begin : drive_bytes
    glyph_xfer_t x;
    if (rst_n && (!drv_valid || byte_taken)) begin
      if (in_gap > 0) begin
        drv_valid <= 1'b0;
        in_gap    <= in_gap - 1;
      end else if (bytes_pending.size() > 0) begin
        x = bytes_pending.pop_front();
        drv_valid <= 1'b1;
        drv_byte  <= x.data;
        drv_last  <= x.last;
        // idle burst before the next byte, none in the tail
        if (bytes_pending.size() >= TailBytes && $urandom_range(0, 5) == 0) begin
          in_gap <= $urandom_range(1, 9);
        end
      end else begin
        drv_valid <= 1'b0;
      end
    end
  end

  // verdict side back pressure in bursts
  always @(negedge clk) begin
    if (rst_n) begin
      if (stall_gap > 0) begin
        drv_stall <= 1'b1;
        stall_gap <= stall_gap - 1;
      end else begin
        drv_stall <= 1'b0;
        if (bytes_pending.size() >= TailBytes && $urandom_range(0, 7) == 0) begin
          stall_gap <= $urandom_range(1, 9);
        end
      end
    end
  end

  // monitor: predict on byte transfers, check on verdict transfers
  always @(posedge clk) begin : watch_ports
    sgoc_res_t due;
    logic      in_fire;
    logic      out_fire;
    if (rst_n) begin
      in_fire  = drv_valid && !in_stall;
      out_fire = out_valid && !drv_stall;
      byte_taken <= in_fire;
      if (in_fire) judge_glyph_byte(drv_byte, drv_last);
      if (out_fire) begin
        if (verdicts_due.size() == 0) begin
          $error("verdict transfer with nothing expected: status %0d count %0d",
                 status, point_count);
          fail_count++;
        end else begin
          due = verdicts_due.pop_front();
          if (status !== due.status) begin
            $error("status: expected %0d, got %0d", due.status, status);
            fail_count++;
          end
          if (point_count !== due.count) begin
            $error("point_count: expected %0d, got %0d", due.count, point_count);
            fail_count++;
          end
        end
      end
      idle_cycles = (in_fire || out_fire) ? 0 : idle_cycles + 1;
    end
  end

  // hang detection
  initial begin
    while (idle_cycles < WatchdogCycles) @(negedge clk);
    $display("Verification failed");
    $finish;
  end

  initial begin
    int pick;
    int ncont;
    int span;
    int ilen;
    int keep;
    int coords;
    int rand_bytes;
    int rand_records;
    restart_glyph();

    // header cut short, one byte and nine bytes
    put_random(1);
    end_record();
    put_word(16'd1);
    put_random(7);
    end_record();
    // zero and negative contour counts
    put_header(16'h0000);
    end_record();
    put_header(16'h8000);
    put_random(5);
    end_record();
    put_header(16'hFFFF);
    put_random(3);
    end_record();
    // smallest complete glyph: one point, no coordinates
    put_header(16'd1);
    put_word(16'd0);
    put_word(16'd0);
    put_byte(FLAG_X_SAME | FLAG_Y_SAME);
    end_record();
    // same, with trailing bytes
    put_header(16'd1);
    put_word(16'd0);
    put_word(16'd0);
    put_byte(8'h30);
    put_random(3);
    end_record();
    // no bits, each short/same bit alone, both short, both same, short with same per axis
    put_header(16'd1);
    put_word(16'd8);
    put_word(16'd1);
    put_random(1);
    coords = 0;
    for (int i = 0; i < 9; i++) begin
      put_byte(flag_mix[i]);
      coords += coord_bytes(flag_mix[i]);
    end
    put_random(coords);
    end_record();
    // repeat flag carrying coordinates
    put_header(16'd1);
    put_word(16'd9);
    put_word(16'd0);
    put_byte(FLAG_REPEAT | FLAG_X_SHORT);
    put_byte(8'd9);
    put_random(10 * coord_bytes(FLAG_REPEAT | FLAG_X_SHORT));
    end_record();
    // equal and falling endpoints
    put_header(16'd2);
    put_word(16'd5);
    put_word(16'd5);
    put_random(6);
    end_record();
    put_header(16'd3);
    put_word(16'd0);
    put_word(16'd9);
    put_word(16'd4);
    end_record();
    // repeat that exactly fills, then one and many too far
    put_header(16'd1);
    put_word(16'd3);
    put_word(16'd0);
    put_byte(8'h38);
    put_byte(8'd3);
    end_record();
    put_header(16'd1);
    put_word(16'd3);
    put_word(16'd0);
    put_byte(8'h38);
    put_byte(8'd4);
    put_random(3);
    end_record();
    put_header(16'd1);
    put_word(16'd3);
    put_word(16'd0);
    put_byte(FLAG_REPEAT);
    put_byte(8'hFF);
    end_record();
    // ends early in endpoints, instructions, flags and coordinates
    put_header(16'h7FFF);
    put_word(16'd1);
    put_word(16'd2);
    put_word(16'd3);
    end_record();
    put_header(16'd1);
    put_word(16'hFFFF);
    put_word(16'hFFFF);
    put_random(4);
    end_record();
    put_header(16'd2);
    put_word(16'd10);
    put_word(16'd20);
    put_word(16'd0);
    put_byte(8'h00);
    end_record();
    put_header(16'd1);
    put_word(16'd1);
    put_word(16'd0);
    put_byte(8'h00);
    put_byte(8'h00);
    put_random(3);
    end_record();
    // largest point total, covered by full repeats with no coordinates
    put_header(16'd1);
    put_word(16'hFFFF);
    put_word(16'd0);
    repeat (256) begin
      put_byte(8'h38);
      put_byte(8'hFF);
    end
    end_record();
    // random good glyph with trailing bytes
    build_glyph(2, 4, 1, FAULT_NONE);
    put_random(5);
    end_record();

    // random part: mostly well-formed glyphs, some broken ones and noise
    rand_bytes   = 0;
    rand_records = 0;
    while (rand_bytes < RandomBytes || rand_records < MinRandomRecords) begin
      pick  = $urandom_range(0, 99);
      ncont = $urandom_range(1, 4);
      span  = $urandom_range(1, 4);
      ilen  = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 24) : $urandom_range(0, 3);
      if (pick < 45) begin
        build_glyph(ncont, span, ilen, FAULT_NONE);
        rand_bytes += rec_buf.size();
        if ($urandom_range(0, 3) == 0) put_random($urandom_range(1, 6));
      end else if (pick < 55) begin
        build_glyph(ncont + 1, span, ilen, FAULT_ORDER);
        rand_bytes += rec_buf.size();
      end else if (pick < 63) begin
        build_glyph(ncont, span, ilen, FAULT_REPEAT);
        rand_bytes += rec_buf.size();
      end else if (pick < 80) begin
        // cut off at a random point
        build_glyph(ncont, span, ilen, FAULT_NONE);
        keep = $urandom_range(1, rec_buf.size() - 1);
        while (rec_buf.size() > keep) void'(rec_buf.pop_back());
        rand_bytes += rec_buf.size();
      end else if (pick < 87) begin
        // one byte overwritten anywhere
        build_glyph(ncont, span, ilen, FAULT_NONE);
        rec_buf[$urandom_range(0, rec_buf.size() - 1)] = 8'($urandom);
        rand_bytes += rec_buf.size();
      end else if (pick < 93) begin
        put_header(($urandom_range(0, 3) == 0) ? 16'h0000 : (16'h8000 | 16'($urandom)));
        rand_bytes += rec_buf.size();
        put_random($urandom_range(0, 12));
      end else begin
        put_random($urandom_range(1, 24));
        rand_bytes += rec_buf.size();
      end
      rand_records++;
      end_record();
    end

    // single reset at the start
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // all bytes transferred, then all verdicts in, then a short drain
    while (bytes_pending.size() != 0 || drv_valid) @(negedge clk);
    while (verdicts_due.size() != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
